// ===== hdl/ps2_mouse_cursor_tracker_unit_defines.svh =====
// Assertion macros shared by the cursor tracker RTL.
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PS2MCT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PS2MCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/ps2mct_pkg.sv =====
// Package: types and constants of the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
`default_nettype none
package ps2mct_pkg;

  localparam logic [7:0]  ACK_BYTE   = 8'hFA;
  localparam int          SIZE_W     = 12;
  localparam logic [11:0] WIDTH_RST  = 12'd320;
  localparam logic [11:0] HEIGHT_RST = 12'd200;
  localparam logic [11:0] POS_X_RST  = 12'd160;
  localparam logic [11:0] POS_Y_RST  = 12'd100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_t;

  // Packet byte positions.
  typedef enum logic [1:0] {
    IDX_HEADER = 2'd0,
    IDX_X      = 2'd1,
    IDX_Y      = 2'd2
  } byte_idx_t;

  // One complete packet, as handed from front to back.
  typedef struct packed {
    logic [2:0] buttons;
    logic       sign_x;
    logic       sign_y;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } pkt_t;

  // Queue occupancy seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Upper clamp: size minus cursor size, saturated at zero.
  function automatic logic [11:0] axis_limit(input logic [11:0] size,
                                             input logic [11:0] cursor);
    axis_limit = (size >= cursor) ? size - cursor : 12'd0;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ps2mct_front.sv =====
// Front end: waits for the acknowledge byte and assembles 3-byte packets.
`timescale 1ns / 1ps
`default_nettype none
module ps2mct_front
  import ps2mct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_accept,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output pkt_t            push_pkt
);

  logic      synced;
  byte_idx_t byte_index;
  logic [7:0] header_byte;
  logic [7:0] x_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      synced     <= 1'b0;
      byte_index <= IDX_HEADER;
    end else if (in_accept) begin
      if (!synced) begin
        // Drop everything until the mouse acknowledges.
        if (in_byte == ACK_BYTE) begin
          synced     <= 1'b1;
          byte_index <= IDX_HEADER;
        end
      end else begin
        case (byte_index)
          IDX_X:   byte_index <= IDX_Y;
          IDX_Y:   byte_index <= IDX_HEADER;
          default: byte_index <= IDX_X;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && synced) begin
      case (byte_index)
        IDX_X:   x_byte      <= in_byte;
        IDX_Y:   ;
        default: header_byte <= in_byte;
      endcase
    end
  end

  assign push = in_accept && synced && (byte_index == IDX_Y);

  always_comb begin
    push_pkt.buttons = header_byte[2:0];
    push_pkt.sign_x  = header_byte[4];
    push_pkt.sign_y  = header_byte[5];
    push_pkt.x_move  = x_byte;
    push_pkt.y_move  = in_byte;
  end

endmodule
`default_nettype wire

// ===== hdl/ps2mct_queue.sv =====
// Two-entry packet queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module ps2mct_queue
  import ps2mct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  input  wire logic pop,
  output pkt_t      pop_pkt,
  output q_stat_t   stat
);

  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  pkt_t       entry [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_pkt;
  end

  assign pop_pkt    = entry[rd_ptr];
  assign stat.full  = count[1];
  assign stat.empty = (count == 2'd0);

endmodule
`default_nettype wire

// ===== hdl/ps2mct_back.sv =====
// Back end: forms deltas, moves and clamps the cursor, holds the result word.
`timescale 1ns / 1ps
`default_nettype none
module ps2mct_back
  import ps2mct_pkg::*;
#(
  parameter int CURSOR_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire q_stat_t     q_stat,
  input  wire pkt_t        pkt,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_buttons,
  output logic [8:0]       out_delta_x,
  output logic [9:0]       out_delta_y,
  output logic [11:0]      out_cursor_x,
  output logic [11:0]      out_cursor_y
);

  localparam logic [11:0] CSIZE     = 12'(CURSOR_SIZE);
  localparam logic [11:0] LIM_X_RST = axis_limit(WIDTH_RST, CSIZE);
  localparam logic [11:0] LIM_Y_RST = axis_limit(HEIGHT_RST, CSIZE);

  logic [11:0] lim_x;
  logic [11:0] lim_y;
  logic [11:0] pos_x;
  logic [11:0] pos_y;

  logic signed [8:0]  dx;
  logic signed [9:0]  dy;
  logic signed [13:0] sum_x;
  logic signed [13:0] sum_y;
  logic [11:0]        pos_x_next;
  logic [11:0]        pos_y_next;

  // Keep the clamp limits rather than the raw sizes.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x <= LIM_X_RST;
      lim_y <= LIM_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  lim_x <= axis_limit(cfg_data, CSIZE);
        REG_HEIGHT: lim_y <= axis_limit(cfg_data, CSIZE);
        default:    ;
      endcase
    end
  end

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_comb begin
    dx    = $signed({pkt.sign_x, pkt.x_move});
    // Negate Y so that down is positive.
    dy    = 10'sd0 - $signed({pkt.sign_y, pkt.sign_y, pkt.y_move});
    sum_x = $signed({2'b00, pos_x}) + 14'(dx);
    sum_y = $signed({2'b00, pos_y}) + 14'(dy);
    if (sum_x < 14'sd0)                         pos_x_next = 12'd0;
    else if (sum_x > $signed({2'b00, lim_x}))   pos_x_next = lim_x;
    else                                        pos_x_next = sum_x[11:0];
    if (sum_y < 14'sd0)                         pos_y_next = 12'd0;
    else if (sum_y > $signed({2'b00, lim_y}))   pos_y_next = lim_y;
    else                                        pos_y_next = sum_y[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_X_RST;
      pos_y     <= POS_Y_RST;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pos_x     <= pos_x_next;
        pos_y     <= pos_y_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_buttons  <= pkt.buttons;
      out_delta_x  <= dx;
      out_delta_y  <= dy;
      out_cursor_x <= pos_x_next;
      out_cursor_y <= pos_y_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ps2_mouse_cursor_tracker_unit.sv =====
// Top level of the PS/2 mouse cursor tracker.
//
//   channel   dir   handshake                       payload
//   s_axis    in    s_axis_tvalid / s_axis_tready   raw mouse byte
//   m_axis    out   m_axis_tvalid / m_axis_tready   buttons, deltas, cursor
//   cfg       in    cfg_valid / cfg_ready           register index, value
//
// One word is taken per cycle while the queue is not full; a packet's result is
// offered once its third byte has passed the queue write and then the output
// register, when the output register is free, one result per cycle at most.
// The rate is set by the single add-and-clamp stage in the back end.
// A two-entry packet queue lets the input run on while the output is stalled;
// s_axis_tready drops only when that queue is full. cfg_ready is always high.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_cursor_tracker_unit_defines.svh"
module ps2_mouse_cursor_tracker_unit
  import ps2mct_pkg::*;
#(
  parameter int CURSOR_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [33:22] cursor_x,
  // [45:34] cursor_y, [47:46] zero
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic       in_accept;
  logic       push;
  pkt_t       push_pkt;
  logic       pop;
  pkt_t       pop_pkt;
  q_stat_t    q_stat;
  logic [2:0]  buttons;
  logic [8:0]  delta_x;
  logic [9:0]  delta_y;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic        drain_last;

  assign s_axis_tready = !q_stat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  ps2mct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_accept),
    .in_byte  (s_axis_tdata),
    .push     (push),
    .push_pkt (push_pkt)
  );

  ps2mct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_pkt(push_pkt),
    .pop     (pop),
    .pop_pkt (pop_pkt),
    .stat    (q_stat)
  );

  ps2mct_back #(
    .CURSOR_SIZE(CURSOR_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .pkt         (pop_pkt),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_buttons (buttons),
    .out_delta_x (delta_x),
    .out_delta_y (delta_y),
    .out_cursor_x(cursor_x),
    .out_cursor_y(cursor_y)
  );

  assign m_axis_tdata = {2'b00, cursor_y, cursor_x, delta_y, delta_x, buttons};

  // Last queued result leaves this cycle.
  assign drain_last = m_axis_tvalid && m_axis_tready && q_stat.empty;

  `PS2MCT_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "packet pushed into full queue")
  `PS2MCT_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "packet popped from empty queue")
  `PS2MCT_ASSERT_NEXT(a_drain, drain_last, !m_axis_tvalid, "result repeated after drain")

endmodule
`default_nettype wire
